// ----- rtl/fnrc_pkg.sv -----
// shared types and constants of the fp64 narrowing converter
package fnrc_pkg;

  // target format codes on the opcode field
  localparam logic [1:0] OP_FP16 = 2'd0;
  localparam logic [1:0] OP_FP32 = 2'd1;
  localparam logic [1:0] OP_BF16 = 2'd2;

  typedef enum logic [1:0] {
    FMT_FP16,
    FMT_FP32,
    FMT_BF16
  } fmt_t;

  typedef enum logic [1:0] {
    RM_RNE = 2'd0,
    RM_RTZ = 2'd1,
    RM_DN  = 2'd2,
    RM_UP  = 2'd3
  } rmode_t;

  localparam logic [31:0] F32_EXP_MASK   = 32'h7f80_0000;
  localparam logic [31:0] F32_FRAC_MASK  = 32'h007f_ffff;
  localparam logic [31:0] F32_QUIET      = 32'h0040_0000;
  localparam logic [31:0] F32_ONE        = 32'h3f80_0000;
  localparam logic [31:0] F32_SIGN       = 32'h8000_0000;
  localparam logic [31:0] F16_SIGN       = 32'h0000_8000;
  localparam logic [12:0] F64_EXP_BIAS   = 13'd1023;
  localparam logic [11:0] F64_UNIT_SHIFT = 12'd1075;
  localparam logic [10:0] F64_EXP_ALL1   = 11'h7ff;
  localparam logic [5:0]  SHIFT_CAP      = 6'd54;

  // request to the rounding stage
  typedef struct packed {
    logic [52:0] mant;
    logic [5:0]  shift;
    rmode_t      mode;
    logic        neg;
  } round_req_t;

endpackage

// ----- rtl/fnrc_in_if.sv -----
// input channel of the converter
interface fnrc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] source_bits;
  logic [1:0]  round_mode;
  logic        flush_subnormal;
  logic        saturate;

  modport source (
    output valid, opcode, source_bits, round_mode, flush_subnormal, saturate,
    input  ready
  );
  modport sink (
    input  valid, opcode, source_bits, round_mode, flush_subnormal, saturate,
    output ready
  );
endinterface

// ----- rtl/fnrc_out_if.sv -----
// result channel of the converter
interface fnrc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;

  modport source (
    output valid, result_bits,
    input  ready
  );
  modport sink (
    input  valid, result_bits,
    output ready
  );
endinterface

// ----- rtl/fp64_narrowing_round_convert_top.sv -----
// top level of the fp64 to fp16 / fp32 / bf16 narrowing converter
// Converts one binary64 pattern per transaction to fp16, fp32 or bf16 (opcode 3 acts as
// fp32), rounding once from the full 53-bit significand in any of four modes, with
// optional flushing of subnormal results and an fp32-only clamp to [0,1]. The block
// takes one transaction every clock cycle while the result side is not stalled; an
// accepted transaction sits in the input register, the single conversion path between
// the two registers produces its result, which is loaded into the result register and
// presented there until taken. A stalled result register backs up into the input
// register, so up to two transactions are held. No configuration, no state between
// transactions, and no start-up pass after reset.
module fp64_narrowing_round_convert_top (
  input logic        clk,
  input logic        rst,
  fnrc_in_if.sink    req,
  fnrc_out_if.source rsp
);

  // input register
  logic        in_valid;
  logic [1:0]  in_opcode;
  logic [63:0] in_source_bits;
  logic [1:0]  in_round_mode;
  logic        in_flush_subnormal;
  logic        in_saturate;

  // result register
  logic        res_valid;
  logic [31:0] res_bits;

  logic [31:0] conv_bits;
  logic        res_free;
  logic        in_move;

  // the result register can load when empty or being drained this cycle
  assign res_free  = !res_valid || rsp.ready;
  assign in_move   = in_valid && res_free;
  assign req.ready = !in_valid || res_free;

  // input register: loads on every accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_opcode          <= req.opcode;
      in_source_bits     <= req.source_bits;
      in_round_mode      <= req.round_mode;
      in_flush_subnormal <= req.flush_subnormal;
      in_saturate        <= req.saturate;
    end
  end

  // the whole conversion sits between the two registers
  fnrc_convert u_convert (
    .opcode          (in_opcode),
    .source_bits     (in_source_bits),
    .round_mode      (in_round_mode),
    .flush_subnormal (in_flush_subnormal),
    .saturate        (in_saturate),
    .result_bits     (conv_bits)
  );

  // result register: holds until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_move) begin
      res_bits <= conv_bits;
    end
  end

  assign rsp.valid       = res_valid;
  assign rsp.result_bits = res_bits;

`ifndef SYNTHESIS
  // an accepted transaction always lands in the input register
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> in_valid)
    else $error("accepted transaction not captured");

  // with both registers full and the output stalled, no new transaction is taken
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && res_valid && !rsp.ready |-> !req.ready)
    else $error("input accepted while pipeline full");

  // a moving transaction shows its converted value in the result register next cycle
  a_move_result: assert property (@(posedge clk) disable iff (rst)
    in_move |=> res_valid && (res_bits == $past(conv_bits)))
    else $error("result register did not take the converted value");
`endif

endmodule

// ----- rtl/fnrc_round.sv -----
// significand alignment and rounding increment
module fnrc_round (
  input  fnrc_pkg::round_req_t req,
  output logic [24:0]          kept_inc
);

  logic [53:0] mant_x;
  logic [53:0] shifted;
  logic [53:0] lo_mask;
  logic [53:0] below_mask;
  logic [5:0]  guard_pos;
  logic        guard;
  logic        sticky;
  logic        rem_nz;
  logic        carry;

  always_comb begin
    mant_x     = {1'b0, req.mant};
    shifted    = mant_x >> req.shift;
    lo_mask    = ~({54{1'b1}} << req.shift);
    below_mask = lo_mask >> 1;
    guard_pos  = req.shift - 6'd1;
    guard      = (req.shift != 6'd0) && mant_x[guard_pos];
    sticky     = |(mant_x & below_mask);
    rem_nz     = |(mant_x & lo_mask);
    case (req.mode)
      fnrc_pkg::RM_RNE: carry = guard && (sticky || shifted[0]);
      fnrc_pkg::RM_RTZ: carry = 1'b0;
      fnrc_pkg::RM_DN:  carry = req.neg && rem_nz;
      fnrc_pkg::RM_UP:  carry = !req.neg && rem_nz;
      default:          carry = 1'b0;
    endcase
    kept_inc = {1'b0, shifted[23:0]} + {24'd0, carry};
  end

endmodule

// ----- rtl/fnrc_convert.sv -----
// classification, exponent handling and result packing of one conversion
module fnrc_convert (
  input  logic [1:0]  opcode,
  input  logic [63:0] source_bits,
  input  logic [1:0]  round_mode,
  input  logic        flush_subnormal,
  input  logic        saturate,
  output logic [31:0] result_bits
);

  fnrc_pkg::fmt_t       fmt;
  fnrc_pkg::rmode_t     mode;
  fnrc_pkg::round_req_t rreq;
  logic [24:0]          kept_inc;

  logic        is32;
  logic [4:0]  fb;
  logic [7:0]  bias;
  logic [7:0]  max_exp;
  logic        neg;
  logic [10:0] e;
  logic [51:0] frac;
  logic [10:0] ex;
  logic [52:0] mant;
  logic signed [12:0] ef;
  logic        sat;
  logic        normal;
  logic        ovf_hit;
  logic [11:0] msh;
  logic [5:0]  shift_sub;
  logic [31:0] sgn;
  logic [31:0] frac_mask;
  logic [31:0] inf_pat;
  logic [31:0] max_fin;
  logic        to_inf;
  logic [31:0] ovf;
  logic [8:0]  ef_inc;
  logic [31:0] pre;

  function automatic logic [31:0] clamp_unit(input logic [31:0] v);
    logic [31:0] r;
    if ((v & fnrc_pkg::F32_EXP_MASK) == fnrc_pkg::F32_EXP_MASK &&
        (v & fnrc_pkg::F32_FRAC_MASK) != 32'd0) r = 32'd0;
    else if (v[31]) r = 32'd0;
    else if (v > fnrc_pkg::F32_ONE) r = fnrc_pkg::F32_ONE;
    else r = v;
    return r;
  endfunction

  // unused opcode falls back to fp32
  always_comb begin
    case (opcode)
      fnrc_pkg::OP_FP16: fmt = fnrc_pkg::FMT_FP16;
      fnrc_pkg::OP_BF16: fmt = fnrc_pkg::FMT_BF16;
      default:           fmt = fnrc_pkg::FMT_FP32;
    endcase
  end

  always_comb begin
    case (fmt)
      fnrc_pkg::FMT_FP16: begin
        fb = 5'd10; bias = 8'd15;  max_exp = 8'd31;
      end
      fnrc_pkg::FMT_BF16: begin
        fb = 5'd7;  bias = 8'd127; max_exp = 8'd255;
      end
      default: begin
        fb = 5'd23; bias = 8'd127; max_exp = 8'd255;
      end
    endcase
  end

  always_comb begin
    mode   = fnrc_pkg::rmode_t'(round_mode);
    is32   = (fmt == fnrc_pkg::FMT_FP32);
    neg    = source_bits[63];
    e      = source_bits[62:52];
    frac   = source_bits[51:0];
    mant   = {(e != 11'd0), frac};
    ex     = (e != 11'd0) ? e : 11'd1;
    ef     = $signed({2'b00, ex}) - $signed(fnrc_pkg::F64_EXP_BIAS)
             + $signed({5'd0, bias});
    sat    = saturate && is32;
    normal = (ef >= 13'sd1);
    ovf_hit = (ef >= $signed({5'd0, max_exp}));
    // right shift into the subnormal grid, capped where nothing of the value is left
    msh    = fnrc_pkg::F64_UNIT_SHIFT + 12'd1 - {4'd0, bias} - {7'd0, fb} - {1'b0, ex};
    shift_sub = (msh > {6'd0, fnrc_pkg::SHIFT_CAP}) ? fnrc_pkg::SHIFT_CAP : msh[5:0];

    rreq.mant  = mant;
    rreq.shift = normal ? (6'd52 - {1'b0, fb}) : shift_sub;
    rreq.mode  = mode;
    rreq.neg   = neg;
  end

  fnrc_round u_round (
    .req      (rreq),
    .kept_inc (kept_inc)
  );

  always_comb begin
    sgn       = neg ? (is32 ? fnrc_pkg::F32_SIGN : fnrc_pkg::F16_SIGN) : 32'd0;
    frac_mask = ~(32'hffff_ffff << fb);
    inf_pat   = sgn | ({24'd0, max_exp} << fb);
    max_fin   = sgn | ({24'd0, max_exp - 8'd1} << fb) | frac_mask;
    to_inf    = (mode == fnrc_pkg::RM_RNE) || (mode == fnrc_pkg::RM_UP && !neg) ||
                (mode == fnrc_pkg::RM_DN && neg);
    if (sat) ovf = neg ? 32'd0 : fnrc_pkg::F32_ONE;
    else     ovf = to_inf ? inf_pat : max_fin;
    ef_inc    = {1'b0, ef[7:0]} + 9'd1;
    pre       = 32'd0;

    if (e == fnrc_pkg::F64_EXP_ALL1) begin
      if (frac != 52'd0) begin
        if (is32) begin
          result_bits = sat ? 32'd0 : (sgn | fnrc_pkg::F32_EXP_MASK |
                        {9'd0, frac[51:29]} | fnrc_pkg::F32_QUIET);
        end else begin
          result_bits = inf_pat | (32'd1 << (fb - 5'd1));
        end
      end else begin
        result_bits = sat ? (neg ? 32'd0 : fnrc_pkg::F32_ONE) : inf_pat;
      end
    end else if (e == 11'd0 && frac == 52'd0) begin
      result_bits = sat ? 32'd0 : sgn;
    end else if (ovf_hit) begin
      result_bits = ovf;
    end else if (normal) begin
      if (kept_inc[fb + 5'd1]) begin
        // rounding carried out of the significand
        if (ef_inc >= {1'b0, max_exp}) begin
          result_bits = ovf;
        end else begin
          pre = sgn | ({23'd0, ef_inc} << fb);
          result_bits = sat ? clamp_unit(pre) : pre;
        end
      end else begin
        pre = sgn | ({24'd0, ef[7:0]} << fb) | ({7'd0, kept_inc} & frac_mask);
        result_bits = sat ? clamp_unit(pre) : pre;
      end
    end else begin
      if (kept_inc[fb]) begin
        // rounded up to the smallest normal, never flushed
        pre = sgn | (32'd1 << fb);
      end else if (flush_subnormal) begin
        pre = (mode == fnrc_pkg::RM_DN) ? sgn : 32'd0;
      end else begin
        pre = sgn | {7'd0, kept_inc};
      end
      result_bits = sat ? clamp_unit(pre) : pre;
    end
  end

endmodule

// ----- sim/testbench.sv -----
// testbench for the fp64 narrowing round-convert block, with its own bit-exact predictor
`timescale 1ns / 100ps

module testbench;

  // opcode 3 is unused and converts as fp32
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic clk;
  logic rst;

  fnrc_in_if  req_if ();
  fnrc_out_if rsp_if ();

  fp64_narrowing_round_convert_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // converted patterns still owed by the block, oldest first
  logic [31:0] pending_results[$];
  logic [31:0] want_bits;
  int          fail_count = 0;
  // random idle bursts on both channels; switched off for the closing stretch
  bit          gaps_on;

  // ---------------------------------------------------------------------------
  // clock, reset and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // generous ceiling for the roughly 1900 transactions of the run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic int frac_width(logic [1:0] op);
    return (op == fnrc_pkg::OP_FP16) ? 10 : (op == fnrc_pkg::OP_BF16) ? 7 : 23;
  endfunction

  function automatic int exp_bias(logic [1:0] op);
    return (op == fnrc_pkg::OP_FP16) ? 15 : 127;
  endfunction

  // whether the kept significand steps up by one unit, given the dropped bits
  function automatic bit rounds_up(logic [1:0] rm, bit neg, logic [63:0] rem, int shift,
                                   logic [63:0] kept);
    logic [63:0] half;
    case (rm)
      fnrc_pkg::RM_RNE: begin
        if (shift <= 0 || shift >= 64) return 1'b0;
        half = 64'd1 << (shift - 1);
        return (rem > half) || (rem == half && kept[0]);
      end
      fnrc_pkg::RM_RTZ: return 1'b0;
      fnrc_pkg::RM_DN: return neg && rem != 0;
      default: return !neg && rem != 0;
    endcase
  endfunction

  // fp32 clamp to [0,1]: nan and anything negative collapse to +0
  function automatic logic [31:0] clamp_unit(logic [31:0] v);
    if ((v & fnrc_pkg::F32_EXP_MASK) == fnrc_pkg::F32_EXP_MASK &&
        (v & fnrc_pkg::F32_FRAC_MASK) != 0) return 32'd0;
    if ((v & fnrc_pkg::F32_SIGN) != 0) return 32'd0;
    if (v > fnrc_pkg::F32_ONE) return fnrc_pkg::F32_ONE;
    return v;
  endfunction

  function automatic logic [31:0] narrow_f64(logic [1:0] op, logic [63:0] src, logic [1:0] rm,
                                             bit ftz, bit sat_req);
    bit          is32, neg, sat;
    int          fb, bias, emax, lsb_exp, e, ex, ef, sh, msh;
    logic [63:0] frac, mant, kept, rem;
    logic [31:0] sgn, inf_pat, ovf, fmask, res;
    is32     = (op == fnrc_pkg::OP_FP32 || op == OP_SPARE);
    fb       = frac_width(op);
    bias     = exp_bias(op);
    emax     = (op == fnrc_pkg::OP_FP16) ? 31 : 255;
    lsb_exp  = 1 - bias - fb;
    neg      = src[63];
    e        = int'(src[62:52]);
    frac     = {12'd0, src[51:0]};
    sat      = sat_req && is32;
    sgn      = !neg ? 32'd0 : (is32 ? fnrc_pkg::F32_SIGN : fnrc_pkg::F16_SIGN);
    fmask    = (32'd1 << fb) - 32'd1;
    inf_pat  = sgn | (32'(emax) << fb);

    if (sat)
      ovf = neg ? 32'd0 : fnrc_pkg::F32_ONE;
    else if (rm == fnrc_pkg::RM_RNE || (rm == fnrc_pkg::RM_UP && !neg) ||
             (rm == fnrc_pkg::RM_DN && neg))
      ovf = inf_pat;
    else
      ovf = sgn | (32'(emax - 1) << fb) | fmask;

    if (src[62:52] == fnrc_pkg::F64_EXP_ALL1) begin
      if (frac != 0) begin
        if (is32) return sat ? 32'd0 : (sgn | fnrc_pkg::F32_EXP_MASK | 32'(frac >> 29) |
                                         fnrc_pkg::F32_QUIET);
        return inf_pat | (32'd1 << (fb - 1));
      end
      if (sat) return neg ? 32'd0 : fnrc_pkg::F32_ONE;
      return inf_pat;
    end
    if (e == 0 && frac == 0) return sat ? clamp_unit(sgn) : sgn;

    mant = (e != 0) ? ((64'd1 << 52) | frac) : frac;
    ex   = (e != 0) ? e : 1;
    ef   = ex - int'(fnrc_pkg::F64_EXP_BIAS) + bias;

    if (ef >= emax) return ovf;

    if (ef >= 1) begin
      // normal result: drop the low 52-fb bits
      sh   = 52 - fb;
      kept = mant >> sh;
      rem  = mant & ((64'd1 << sh) - 64'd1);
      res  = sgn | (32'(ef) << fb) | (32'(kept) & fmask);
      if (rounds_up(rm, neg, rem, sh, kept)) begin
        kept = kept + 64'd1;
        if (kept == (64'd1 << (fb + 1))) begin
          if (ef + 1 >= emax) return sat ? clamp_unit(ovf) : ovf;
          res = sgn | (32'(ef + 1) << fb);
        end else begin
          res = sgn | (32'(ef) << fb) | (32'(kept) & fmask);
        end
      end
      return sat ? clamp_unit(res) : res;
    end

    // subnormal result, measured in units of the smallest target subnormal
    msh = int'(fnrc_pkg::F64_UNIT_SHIFT) + lsb_exp - ex;
    if (msh >= 53) begin
      kept = 64'd0;
      rem  = mant;
    end else begin
      kept = mant >> msh;
      rem  = mant & ((64'd1 << msh) - 64'd1);
    end
    if (rounds_up(rm, neg, rem, msh, kept)) kept = kept + 64'd1;
    if (kept >= (64'd1 << fb)) begin
      // carried into the smallest normal, never flushed
      res = sgn | (32'd1 << fb);
    end else begin
      res = sgn | 32'(kept);
      if (ftz) res = (rm == fnrc_pkg::RM_DN) ? sgn : 32'd0;
    end
    return sat ? clamp_unit(res) : res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus shaping
  // ---------------------------------------------------------------------------
  // mostly values whose exponent lands near the target range, with dropped bits often
  // forced to ties, all ones or zero; the rest is specials and raw random patterns
  function automatic logic [63:0] pick_source(logic [1:0] op);
    int          kind, fb, bias, emax, ef, sh;
    bit          sgn_b, keep_b;
    logic [63:0] frac, low;
    logic [10:0] ebits;
    fb    = frac_width(op);
    bias  = exp_bias(op);
    emax  = (op == fnrc_pkg::OP_FP16) ? 31 : 255;
    kind  = int'($urandom_range(0, 9));
    sgn_b = 1'($urandom_range(0, 1));
    keep_b = 1'($urandom_range(0, 1));
    frac  = {$urandom, $urandom};
    frac[63:52] = 12'd0;
    case (kind)
      0: return {$urandom, $urandom};
      1: return {sgn_b, fnrc_pkg::F64_EXP_ALL1, keep_b ? frac[51:0] : 52'd0};
      2: return {sgn_b, 11'd0, keep_b ? frac[51:0] : (frac[51:0] >> $urandom_range(0, 51))};
      default: begin
        ef    = int'($urandom_range(0, emax + fb + 4)) - (fb + 3);
        ebits = 11'(ef - bias + int'(fnrc_pkg::F64_EXP_BIAS));
        sh    = (ef >= 1) ? 52 - fb : 52 - fb + 1 - ef;
        if (sh > 52) sh = 52;
        low = (64'd1 << sh) - 64'd1;
        case ($urandom_range(0, 4))
          0: frac = (frac & ~low) | (64'd1 << (sh - 1));
          1: frac = frac | low;
          2: frac = frac & ~low;
          3: frac = frac | ~low;
          default: ;
        endcase
        return {sgn_b, ebits, frac[51:0]};
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request side: one transaction per call, valid left high for the next call
  // ---------------------------------------------------------------------------
  task automatic send_conv(input logic [1:0] op, input logic [63:0] src, input logic [1:0] rm,
                           input bit ftz, input bit sat);
    int gap;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid           <= 1'b1;
    req_if.opcode          <= op;
    req_if.source_bits     <= src;
    req_if.round_mode      <= rm;
    req_if.flush_subnormal <= ftz;
    req_if.saturate        <= sat;
    do @(posedge clk); while (!req_if.ready);
    pending_results.push_back(narrow_f64(op, src, rm, ftz, sat));
  endtask

  task automatic send_random(input int count);
    logic [1:0] op;
    repeat (count) begin
      op = 2'($urandom_range(0, 3));
      send_conv(op, pick_source(op), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, and the comparison against the oldest expectation
  // ---------------------------------------------------------------------------
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result_bits: no transaction outstanding, actual %h", rsp_if.result_bits);
        fail_count++;
      end else begin
        want_bits = pending_results.pop_front();
        if (rsp_if.result_bits !== want_bits) begin
          $error("result_bits mismatch: expected %h, actual %h", want_bits,
                 rsp_if.result_bits);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // zeros, infinities, nans, overflow, ties, subnormals, flushing and the clamp
  task automatic test_special_values;
    send_conv(fnrc_pkg::OP_FP32, 64'h0000_0000_0000_0000, fnrc_pkg::RM_RNE, 1'b0, 1'b1);
    send_conv(fnrc_pkg::OP_FP16, 64'h8000_0000_0000_0000, fnrc_pkg::RM_DN,  1'b0, 1'b0);
    send_conv(fnrc_pkg::OP_FP32, 64'h8000_0000_0000_0000, fnrc_pkg::RM_RTZ, 1'b0, 1'b1);
    send_conv(fnrc_pkg::OP_BF16, 64'h7ff0_0000_0000_0000, fnrc_pkg::RM_RTZ, 1'b0, 1'b0);
    send_conv(fnrc_pkg::OP_FP32, 64'hfff0_0000_0000_0000, fnrc_pkg::RM_UP,  1'b0, 1'b1);
    send_conv(fnrc_pkg::OP_FP32, 64'h7ff0_0000_0000_0000, fnrc_pkg::RM_DN,  1'b0, 1'b1);
    // nan payloads: fp32 keeps the top bits, the narrow formats give a plain quiet nan
    send_conv(fnrc_pkg::OP_FP32, 64'h7ff8_0000_2000_0001, fnrc_pkg::RM_RNE, 1'b0, 1'b0);
    send_conv(fnrc_pkg::OP_FP16, 64'hfff0_0000_2000_0000, fnrc_pkg::RM_RNE, 1'b0, 1'b0);
    send_conv(fnrc_pkg::OP_BF16, 64'h7ff4_0000_0000_0000, fnrc_pkg::RM_UP,  1'b1, 1'b1);
    send_conv(fnrc_pkg::OP_FP32, 64'h7ff0_0000_0000_0001, fnrc_pkg::RM_RNE, 1'b0, 1'b1);
    send_conv(OP_SPARE, 64'hffff_ffff_ffff_ffff, fnrc_pkg::RM_UP, 1'b1, 1'b1);
    // overflow: largest finite or infinity depending on mode and sign
    send_conv(fnrc_pkg::OP_FP16, 64'h7fef_ffff_ffff_ffff, fnrc_pkg::RM_RTZ, 1'b0, 1'b0);
    send_conv(fnrc_pkg::OP_FP32, 64'h7fef_ffff_ffff_ffff, fnrc_pkg::RM_DN,  1'b0, 1'b0);
    send_conv(fnrc_pkg::OP_BF16, 64'hffef_ffff_ffff_ffff, fnrc_pkg::RM_UP,  1'b0, 1'b0);
    send_conv(fnrc_pkg::OP_BF16, 64'hffef_ffff_ffff_ffff, fnrc_pkg::RM_DN,  1'b0, 1'b0);
    send_conv(fnrc_pkg::OP_FP16, 64'h40ef_fe00_0000_0000, fnrc_pkg::RM_RNE, 1'b0, 1'b0);
    // ties to even, down and up
    send_conv(fnrc_pkg::OP_FP16, 64'h3ff0_0200_0000_0000, fnrc_pkg::RM_RNE, 1'b0, 1'b0);
    send_conv(fnrc_pkg::OP_FP16, 64'h3ff0_0600_0000_0000, fnrc_pkg::RM_RNE, 1'b0, 1'b0);
    send_conv(fnrc_pkg::OP_BF16, 64'h3ff0_1000_0000_0001, fnrc_pkg::RM_UP,  1'b0, 1'b0);
    // source subnormals are used at full value
    send_conv(fnrc_pkg::OP_FP32, 64'h0000_0000_0000_0001, fnrc_pkg::RM_UP,  1'b0, 1'b0);
    send_conv(fnrc_pkg::OP_FP16, 64'h8000_0000_0000_0001, fnrc_pkg::RM_DN,  1'b0, 1'b0);
    // flushing: signed zero only under round-down; carry into min normal survives
    send_conv(fnrc_pkg::OP_FP16, 64'hbeb0_0000_0000_0000, fnrc_pkg::RM_DN,  1'b1, 1'b0);
    send_conv(fnrc_pkg::OP_FP16, 64'h3eb0_0000_0000_0000, fnrc_pkg::RM_RNE, 1'b1, 1'b0);
    send_conv(fnrc_pkg::OP_FP32, 64'h380f_ffff_ffff_ffff, fnrc_pkg::RM_RNE, 1'b1, 1'b0);
    // clamp on fp32 only
    send_conv(fnrc_pkg::OP_FP32, 64'h3fe0_0000_0000_0000, fnrc_pkg::RM_RNE, 1'b0, 1'b1);
    send_conv(fnrc_pkg::OP_FP32, 64'h3ff8_0000_0000_0000, fnrc_pkg::RM_RNE, 1'b0, 1'b1);
    send_conv(fnrc_pkg::OP_FP32, 64'hbfe0_0000_0000_0000, fnrc_pkg::RM_RNE, 1'b0, 1'b1);
    send_conv(fnrc_pkg::OP_FP16, 64'h4000_0000_0000_0000, fnrc_pkg::RM_RNE, 1'b0, 1'b1);
  endtask

  // near-boundary values in every format and mode, both sides stalling
  task automatic test_rounding_boundaries;
    send_random(900);
  endtask

  // raw random patterns mixed in more heavily, still with stalls
  task automatic test_mixed_patterns;
    logic [1:0] op;
    repeat (650) begin
      op = 2'($urandom_range(0, 3));
      send_conv(op, ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} : pick_source(op),
                2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
  endtask

  // closing stretch at full rate: no gaps on either side
  task automatic test_full_rate;
    gaps_on = 1'b0;
    send_random(280);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    gaps_on                       = 1'b1;
    rst                           = 1'b1;
    req_if.valid                  = 1'b0;
    req_if.opcode                 = fnrc_pkg::OP_FP16;
    req_if.source_bits            = 64'd0;
    req_if.round_mode             = fnrc_pkg::RM_RNE;
    req_if.flush_subnormal        = 1'b0;
    req_if.saturate               = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_special_values();
    test_rounding_boundaries();
    test_mixed_patterns();
    test_full_rate();

    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // keep the clock running so that any stray transaction would be caught
    repeat (8) @(posedge clk);

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fnrc_pkg.sv
rtl/fnrc_in_if.sv
rtl/fnrc_out_if.sv
rtl/fnrc_round.sv
rtl/fnrc_convert.sv
rtl/fp64_narrowing_round_convert_top.sv
sim/testbench.sv
